// ===== hdl/plx_pkg.sv =====
`timescale 1ns / 1ps

package plx_pkg;

   // Token kinds
   localparam logic [5:0] KIND_IDENT  = 6'd19;
   localparam logic [5:0] KIND_INT    = 6'd20;
   localparam logic [5:0] KIND_EQ     = 6'd21;
   localparam logic [5:0] KIND_PLUS   = 6'd22;
   localparam logic [5:0] KIND_MINUS  = 6'd23;
   localparam logic [5:0] KIND_STAR   = 6'd24;
   localparam logic [5:0] KIND_SLASH  = 6'd25;
   localparam logic [5:0] KIND_COLON  = 6'd26;
   localparam logic [5:0] KIND_COMMA  = 6'd27;
   localparam logic [5:0] KIND_LPAREN = 6'd28;
   localparam logic [5:0] KIND_RPAREN = 6'd29;
   localparam logic [5:0] KIND_ASSIGN = 6'd30;
   localparam logic [5:0] KIND_LE     = 6'd31;
   localparam logic [5:0] KIND_LT     = 6'd32;
   localparam logic [5:0] KIND_GE     = 6'd33;
   localparam logic [5:0] KIND_GT     = 6'd34;
   localparam logic [5:0] KIND_EOF    = 6'd35;

   // Default parameter values
   localparam int unsigned MAX_TEXT_LEN_DEF  = 65536;
   localparam int unsigned KEYWORD_BYTES_DEF = 10;

   // Depth of the result queue; it must hold at least two beats
   localparam int unsigned OUT_DEPTH = 4;

   // Keyword table: text right-justified, so the first byte sits highest
   localparam int unsigned KW_COUNT   = 21;
   localparam int unsigned KW_MAX_LEN = 10;

   localparam logic [79:0] KW_TEXT [KW_COUNT] = '{
      80'("Program"), 80'("endprogram"), 80'("int"), 80'("input"), 80'("output"),
      80'("for"), 80'("to"), 80'("do"), 80'("endfor"), 80'("while"),
      80'("endwhile"), 80'("if"), 80'("then"), 80'("else"), 80'("endif"),
      80'("AND"), 80'("OR"), 80'("true"), 80'("TRUE"), 80'("false"), 80'("FALSE")
   };
   localparam logic [4:0] KW_LEN [KW_COUNT] = '{
      5'd7, 5'd10, 5'd3, 5'd5, 5'd6, 5'd3, 5'd2, 5'd2, 5'd6, 5'd5, 5'd8,
      5'd2, 5'd4, 5'd4, 5'd5, 5'd3, 5'd2, 5'd4, 5'd4, 5'd5, 5'd5
   };
   localparam logic [5:0] KW_KIND [KW_COUNT] = '{
      6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10,
      6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd17, 6'd18, 6'd18
   };

   // Characters of interest
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;

   // One result beat
   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [7:0]  char_code;
      logic        last;
   } plx_token_type;

   // Results produced by one accepted input beat, packed to the front
   typedef struct packed {
      logic [1:0]    count;
      plx_token_type slot0;
      plx_token_type slot1;
   } plx_emit_type;

   // Queue status seen by the top level
   typedef struct packed {
      logic [$clog2(OUT_DEPTH+1)-1:0] level;
      logic                           room;
   } plx_queue_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
   endfunction

   // Single-byte operator: bit 6 flags a hit, bits 5:0 give the kind
   function automatic logic [6:0] single_op(input logic [7:0] c);
      logic [6:0] r;
      case (c)
         8'h3D:   r = {1'b1, KIND_EQ};
         8'h2B:   r = {1'b1, KIND_PLUS};
         8'h2D:   r = {1'b1, KIND_MINUS};
         8'h2A:   r = {1'b1, KIND_STAR};
         8'h2F:   r = {1'b1, KIND_SLASH};
         8'h3A:   r = {1'b1, KIND_COLON};
         8'h2C:   r = {1'b1, KIND_COMMA};
         8'h28:   r = {1'b1, KIND_LPAREN};
         8'h29:   r = {1'b1, KIND_RPAREN};
         default: r = {1'b0, KIND_IDENT};
      endcase
      return r;
   endfunction

   // Parallel keyword compare; byte i of the buffer sits at bits 8*i+7:8*i
   function automatic logic [5:0] kw_lookup(input logic [8*KW_MAX_LEN-1:0] kb,
                                            input logic [4:0] cnt);
      logic [5:0] kind;
      logic       hit;
      kind = KIND_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         hit = (cnt == KW_LEN[k]);
         for (int i = 0; i < KW_MAX_LEN; i++) begin
            if (i < int'(KW_LEN[k])) begin
               hit = hit && (kb[8*i +: 8] == KW_TEXT[k][8*(int'(KW_LEN[k])-1-i) +: 8]);
            end
         end
         if (hit) begin
            kind = KW_KIND[k];
         end
      end
      return kind;
   endfunction

endpackage

// ===== hdl/pseudocode_lexer.sv =====
`timescale 1ns / 1ps

// Channel | Direction | tdata (low bit up)                    | tuser           | tlast
// req     | in        | in_char[7:0]                          | -               | end_of_text
// rsp     | out       | start[15:0] length[15:0] char[7:0]    | token_kind[5:0] | last_of_run
//
// Each request beat is decoded in the cycle it is accepted; its tokens, if any
// (up to two), enter a four-beat result queue and can appear on rsp from the next cycle.
// Requests are taken every cycle while the queue has room for two beats, so the
// sustained rate is one byte per cycle as long as tokens drain at one per cycle.
// Reset is synchronous and clears the scanner state, the position and the queue.
// A stalled rsp side fills the queue and then holds off req.

module pseudocode_lexer #(
   parameter int unsigned MAX_TEXT_LEN  = plx_pkg::MAX_TEXT_LEN_DEF,
   parameter int unsigned KEYWORD_BYTES = plx_pkg::KEYWORD_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_char[7:0]
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // token_start[15:0], token_length[31:16],
                                    // token_char[39:32]
   output logic [5:0]  rsp_tuser,   // token_kind[5:0]
   output logic        rsp_tlast    // last_of_run
);
   import plx_pkg::*;

   logic          req_fire;
   logic          rsp_fire;
   plx_emit_type  emit;
   plx_token_type head;
   plx_queue_type status;

   assign req_tready = status.room;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = status.level != '0;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   // Scanner: one byte per accepted beat
   plx_scan #(
      .MAX_TEXT_LEN (MAX_TEXT_LEN),
      .KEYWORD_BYTES(KEYWORD_BYTES)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .beat       (req_fire),
      .in_char    (req_tdata),
      .end_of_text(req_tlast),
      .emit       (emit)
   );

   // Result queue decouples the two sides
   plx_queue u_queue (
      .clock (clock),
      .reset (reset),
      .emit  (emit),
      .pop   (rsp_fire),
      .head  (head),
      .status(status)
   );

   // Output beat packing
   assign rsp_tdata = {head.char_code, head.length, head.start};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   // Queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      status.level <= ($clog2(OUT_DEPTH+1))'(OUT_DEPTH))
      else $error("result queue overflow");

   // No tokens without an accepted request beat
   assert property (@(posedge clock) disable iff (reset)
      !req_fire |-> emit.count == 2'd0)
      else $error("tokens emitted without a request beat");

   // End of text always finishes with an end-of-file token
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |->
         ((emit.count == 2'd1 && emit.slot0.kind == KIND_EOF) ||
          (emit.count == 2'd2 && emit.slot1.kind == KIND_EOF)))
      else $error("end of text without end-of-file token");

   // Two results: only the second carries the last flag
   assert property (@(posedge clock) disable iff (reset)
      emit.count == 2'd2 |-> (!emit.slot0.last && emit.slot1.last))
      else $error("wrong last flag on a double result");

endmodule

// ===== hdl/plx_scan.sv =====
`timescale 1ns / 1ps

module plx_scan #(
   parameter int unsigned MAX_TEXT_LEN  = plx_pkg::MAX_TEXT_LEN_DEF,
   parameter int unsigned KEYWORD_BYTES = plx_pkg::KEYWORD_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  beat,
   input  logic [7:0]            in_char,
   input  logic                  end_of_text,
   output plx_pkg::plx_emit_type emit
);
   import plx_pkg::*;

   localparam int unsigned POS_CAP_I = (MAX_TEXT_LEN - 1 > 65535) ? 65535 : MAX_TEXT_LEN - 1;
   localparam logic [15:0] POS_CAP   = 16'(POS_CAP_I);
   localparam int unsigned CNT_W     = $clog2(KEYWORD_BYTES + 1);
   localparam int unsigned IDX_W     = $clog2(KW_MAX_LEN);

   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_IDENT   = 5'b00010,
      MODE_NUMBER  = 5'b00100,
      MODE_LESS    = 5'b01000,
      MODE_GREATER = 5'b10000
   } plx_mode_type;

   plx_mode_type            mode_ff, mode_in;
   logic [15:0]             pos_ff, pos_in;
   logic [15:0]             pstart_ff, pstart_in;
   logic [7:0]              pfirst_ff, pfirst_in;
   logic                    too_long_ff, too_long_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [8*KW_MAX_LEN-1:0] kbuf_ff, kbuf_in;

   logic [7:0]    c;
   logic          fresh;
   logic          e0_valid, e1_valid;
   plx_token_type e0, e1;
   logic [6:0]    op;
   logic [15:0]   span;

   assign c    = end_of_text ? CH_NUL : in_char;
   assign op   = single_op(c);
   assign span = pos_ff - pstart_ff;

   // Extend or close the pending token, then treat a byte that it did not take afresh
   always_comb begin
      mode_in     = mode_ff;
      pstart_in   = pstart_ff;
      pfirst_in   = pfirst_ff;
      too_long_in = too_long_ff;
      count_in    = count_ff;
      kbuf_in     = kbuf_ff;
      fresh       = 1'b1;
      e0_valid    = 1'b0;
      e1_valid    = 1'b0;
      e0          = '{kind: KIND_IDENT, start: pstart_ff, length: span,
                      char_code: pfirst_ff, last: 1'b0};
      e1          = '{kind: KIND_IDENT, start: pos_ff, length: 16'd1,
                      char_code: c, last: 1'b0};

      case (mode_ff)
         MODE_IDENT: begin
            if (is_letter(c)) begin
               fresh = 1'b0;
               if (count_ff < CNT_W'(KEYWORD_BYTES)) begin
                  if (count_ff < CNT_W'(KW_MAX_LEN)) begin
                     kbuf_in[8*count_ff[IDX_W-1:0] +: 8] = c;
                  end
                  count_in = count_ff + 1'b1;
               end else begin
                  too_long_in = 1'b1;
               end
            end else begin
               e0_valid = 1'b1;
               e0.kind  = too_long_ff ? KIND_IDENT : kw_lookup(kbuf_ff, 5'(count_ff));
            end
         end
         MODE_NUMBER: begin
            if (is_digit(c)) begin
               fresh = 1'b0;
            end else begin
               e0_valid = 1'b1;
               e0.kind  = KIND_INT;
            end
         end
         MODE_LESS: begin
            e0_valid     = 1'b1;
            e0.char_code = CH_LT;
            if (c == CH_MINUS || c == CH_EQ) begin
               fresh     = 1'b0;
               e0.kind   = (c == CH_MINUS) ? KIND_ASSIGN : KIND_LE;
               e0.length = 16'd2;
            end else begin
               e0.kind   = KIND_LT;
               e0.length = 16'd1;
            end
         end
         MODE_GREATER: begin
            e0_valid     = 1'b1;
            e0.char_code = CH_GT;
            if (c == CH_EQ) begin
               fresh     = 1'b0;
               e0.kind   = KIND_GE;
               e0.length = 16'd2;
            end else begin
               e0.kind   = KIND_GT;
               e0.length = 16'd1;
            end
         end
         default: begin
         end
      endcase

      if (fresh) begin
         mode_in = MODE_IDLE;
         if (c == CH_NUL) begin
            e1_valid     = 1'b1;
            e1.kind      = KIND_EOF;
            e1.length    = 16'd0;
            e1.char_code = CH_NUL;
         end else if (is_space(c)) begin
            // whitespace gives no token
         end else if (op[6]) begin
            e1_valid = 1'b1;
            e1.kind  = op[5:0];
         end else if (is_letter(c) || is_digit(c) || c == CH_LT || c == CH_GT) begin
            pstart_in   = pos_ff;
            pfirst_in   = c;
            too_long_in = 1'b0;
            count_in    = '0;
            if (is_letter(c)) begin
               mode_in         = MODE_IDENT;
               kbuf_in[7:0]    = c;
               count_in        = CNT_W'(1);
            end else if (is_digit(c)) begin
               mode_in = MODE_NUMBER;
            end else if (c == CH_LT) begin
               mode_in = MODE_LESS;
            end else begin
               mode_in = MODE_GREATER;
            end
         end else begin
            // unknown byte is a one-byte identifier
            e1_valid = 1'b1;
         end
      end else if (mode_ff == MODE_LESS || mode_ff == MODE_GREATER) begin
         mode_in = MODE_IDLE;
      end

      if (fresh && c == CH_NUL) begin
         pos_in = '0;
      end else if (pos_ff < POS_CAP) begin
         pos_in = pos_ff + 16'd1;
      end else begin
         pos_in = pos_ff;
      end
   end

   // Pack the results to the front and mark the final one
   always_comb begin
      emit       = '0;
      emit.count = beat ? (2'(e0_valid) + 2'(e1_valid)) : 2'd0;
      emit.slot0 = e0_valid ? e0 : e1;
      emit.slot1 = e1;
      emit.slot0.last = !(e0_valid && e1_valid);
      emit.slot1.last = 1'b1;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         pos_ff      <= '0;
         pstart_ff   <= '0;
         pfirst_ff   <= '0;
         too_long_ff <= 1'b0;
         count_ff    <= '0;
      end else if (beat) begin
         mode_ff     <= mode_in;
         pos_ff      <= pos_in;
         pstart_ff   <= pstart_in;
         pfirst_ff   <= pfirst_in;
         too_long_ff <= too_long_in;
         count_ff    <= count_in;
      end
   end

   // Keyword buffer needs no reset: only written bytes are compared
   always_ff @(posedge clock) begin
      if (beat) begin
         kbuf_ff <= kbuf_in;
      end
   end

endmodule

// ===== hdl/plx_queue.sv =====
`timescale 1ns / 1ps

module plx_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  plx_pkg::plx_emit_type  emit,
   input  logic                   pop,
   output plx_pkg::plx_token_type head,
   output plx_pkg::plx_queue_type status
);
   import plx_pkg::*;

   localparam int unsigned PTR_W = $clog2(OUT_DEPTH);
   localparam int unsigned LVL_W = $clog2(OUT_DEPTH + 1);

   plx_token_type    mem_ff [OUT_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic [PTR_W-1:0] wr_next;

   assign wr_next = wr_ff + PTR_W'(1);
   assign wr_in   = wr_ff + PTR_W'(emit.count);
   assign rd_in   = rd_ff + PTR_W'(pop);
   assign level_in = level_ff + LVL_W'(emit.count) - LVL_W'(pop);

   assign head          = mem_ff[rd_ff];
   assign status.level  = level_ff;
   assign status.room   = level_ff <= LVL_W'(OUT_DEPTH - 2);

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

   // Up to two beats written per cycle
   always_ff @(posedge clock) begin
      if (emit.count != 2'd0) begin
         mem_ff[wr_ff] <= emit.slot0;
      end
      if (emit.count == 2'd2) begin
         mem_ff[wr_next] <= emit.slot1;
      end
   end

endmodule
